FILE: rtl/gcdb_pkg.sv
// ----------------------------------------------------------------------------
// gcdb_pkg: shared constants and helpers for the great-circle distance block
// Angle units, CORDIC table, datapath widths and pipeline latencies.
// ----------------------------------------------------------------------------
package gcdb_pkg;

  // Internal angle unit is 2^-17 degree.
  localparam int ANG_TURN         = 47185920;
  localparam int ANG_HALF         = 23592960;
  localparam int ANG_QUARTER      = 11796480;
  localparam int Q_FRAC           = 30;
  localparam int Q30_ONE          = 1073741824;
  localparam int CORDIC_GAIN      = 652032874;
  localparam int CORDIC_STEPS     = 23;
  localparam int DIST_MUL         = 116596331;
  localparam int DIST_MAX         = 320256;
  localparam int OUT_BEARING_TURN = 23592960;
  localparam int NORM_BIT         = 40;

  // Widths
  localparam int ANG_W  = 27;  // angle fed to sin/cos
  localparam int RES_W  = 26;  // residual / accumulated angle
  localparam int TRIG_W = 33;  // Q30 trig values and products
  localparam int VEC_W  = 34;  // atan2 operands
  localparam int SQ_W   = 31;  // square-root argument and root
  localparam int SQ_STEPS = 31;

  // Latencies in register stages
  localparam int SC_LAT  = 2 + CORDIC_STEPS + 1;
  localparam int ATN_LAT = 4 + CORDIC_STEPS + 1;
  localparam int BRG_DLY = 4 + SQ_STEPS - 3;
  localparam int LATENCY = 1 + SC_LAT + 4 + SQ_STEPS + ATN_LAT + 2;

  localparam logic signed [RES_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    26'sd5898240, 26'sd3481934, 26'sd1839759, 26'sd933890, 26'sd468757,
    26'sd234607, 26'sd117332, 26'sd58670, 26'sd29335, 26'sd14668,
    26'sd7334, 26'sd3667, 26'sd1833, 26'sd917, 26'sd458, 26'sd229,
    26'sd115, 26'sd57, 26'sd29, 26'sd14, 26'sd7, 26'sd4, 26'sd2
  };

  // Q30 product with floor shift
  function automatic logic signed [TRIG_W-1:0] mul_q30(
    input logic signed [TRIG_W-1:0] a,
    input logic signed [TRIG_W-1:0] b
  );
    logic signed [2*TRIG_W-1:0] p;
    p = a * b;
    return TRIG_W'(p >>> Q_FRAC);
  endfunction

endpackage

FILE: rtl/gcdb_sincos.sv
// ----------------------------------------------------------------------------
// gcdb_sincos: pipelined rotation CORDIC
// Reduces the angle to one turn, folds it into [-90,90] degrees, then runs
// one CORDIC iteration per stage. Q30 sine and cosine out.
// ----------------------------------------------------------------------------
module gcdb_sincos (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic signed [gcdb_pkg::ANG_W-1:0]       angle,
  output logic                                    out_valid,
  output logic signed [gcdb_pkg::TRIG_W-1:0]      sin_val,
  output logic signed [gcdb_pkg::TRIG_W-1:0]      cos_val
);
  import gcdb_pkg::*;

  logic signed [ANG_W:0]    a_ext;
  logic signed [ANG_W:0]    wrap;
  logic                     w_v;
  logic signed [RES_W-1:0]  w_r;

  logic                     it_v   [CORDIC_STEPS+1];
  logic                     it_neg [CORDIC_STEPS+1];
  logic signed [RES_W-1:0]  it_r   [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] it_x   [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] it_y   [CORDIC_STEPS+1];

  // Bring the angle into [-180,180) with one add or subtract of a turn
  always_comb begin
    a_ext = (ANG_W+1)'(angle);
    priority if (a_ext >= (ANG_W+1)'(ANG_HALF)) begin
      wrap = a_ext - (ANG_W+1)'(ANG_TURN);
    end else if (a_ext < -(ANG_W+1)'(ANG_HALF)) begin
      wrap = a_ext + (ANG_W+1)'(ANG_TURN);
    end else begin
      wrap = a_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_v      <= 1'b0;
      it_v[0]  <= 1'b0;
    end else begin
      w_v      <= in_valid;
      it_v[0]  <= w_v;
    end
  end

  // Fold into [-90,90], remember cosine sign
  always_ff @(posedge clk) begin
    w_r     <= RES_W'(wrap);
    it_x[0] <= TRIG_W'(CORDIC_GAIN);
    it_y[0] <= '0;
    priority if (w_r > RES_W'(ANG_QUARTER)) begin
      it_r[0]   <= RES_W'(ANG_HALF) - w_r;
      it_neg[0] <= 1'b1;
    end else if (w_r < -RES_W'(ANG_QUARTER)) begin
      it_r[0]   <= -RES_W'(ANG_HALF) - w_r;
      it_neg[0] <= 1'b1;
    end else begin
      it_r[0]   <= w_r;
      it_neg[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        it_v[i+1] <= 1'b0;
      end else begin
        it_v[i+1] <= it_v[i];
      end
    end

    always_ff @(posedge clk) begin
      it_neg[i+1] <= it_neg[i];
      if (!it_r[i][RES_W-1]) begin
        it_x[i+1] <= it_x[i] - (it_y[i] >>> i);
        it_y[i+1] <= it_y[i] + (it_x[i] >>> i);
        it_r[i+1] <= it_r[i] - ATAN_TAB[i];
      end else begin
        it_x[i+1] <= it_x[i] + (it_y[i] >>> i);
        it_y[i+1] <= it_y[i] - (it_x[i] >>> i);
        it_r[i+1] <= it_r[i] + ATAN_TAB[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= it_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    sin_val <= it_y[CORDIC_STEPS];
    cos_val <= it_neg[CORDIC_STEPS] ? -it_x[CORDIC_STEPS] : it_x[CORDIC_STEPS];
  end

endmodule

FILE: rtl/gcdb_atan2.sv
// ----------------------------------------------------------------------------
// gcdb_atan2: pipelined vectoring CORDIC
// Turns the vector into the right half plane, normalizes it in two shift
// stages, then runs one CORDIC iteration per stage. Zero vector gives zero.
// ----------------------------------------------------------------------------
module gcdb_atan2 (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic signed [gcdb_pkg::VEC_W-1:0]     vec_y,
  input  logic signed [gcdb_pkg::VEC_W-1:0]     vec_x,
  output logic                                  out_valid,
  output logic signed [gcdb_pkg::RES_W-1:0]     angle
);
  import gcdb_pkg::*;

  localparam int PW  = VEC_W + 1;
  localparam int MXW = NORM_BIT + 2;
  localparam int NW  = NORM_BIT + 6;

  logic                     p_v, p_zero;
  logic signed [PW-1:0]     p_x, p_y;
  logic signed [RES_W-1:0]  p_z;

  logic                     m_v, m_zero;
  logic signed [PW-1:0]     m_x, m_y;
  logic [MXW-1:0]           m_mx;
  logic signed [RES_W-1:0]  m_z;
  logic [PW-1:0]            abs_x, abs_y;

  logic [MXW-1:0]           c1_mx, c2_mx;
  logic signed [NW-1:0]     c1_x, c1_y, c2_x, c2_y;
  logic                     n1_v, n1_zero;
  logic [MXW-1:0]           n1_mx;
  logic signed [NW-1:0]     n1_x, n1_y;
  logic signed [RES_W-1:0]  n1_z;

  logic                     it_v    [CORDIC_STEPS+1];
  logic                     it_zero [CORDIC_STEPS+1];
  logic signed [NW-1:0]     it_x    [CORDIC_STEPS+1];
  logic signed [NW-1:0]     it_y    [CORDIC_STEPS+1];
  logic signed [RES_W-1:0]  it_z    [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v     <= 1'b0;
      m_v     <= 1'b0;
      n1_v    <= 1'b0;
      it_v[0] <= 1'b0;
    end else begin
      p_v     <= in_valid;
      m_v     <= p_v;
      n1_v    <= m_v;
      it_v[0] <= n1_v;
    end
  end

  // Pre-rotate by +-90 degrees when x is negative
  always_ff @(posedge clk) begin
    p_zero <= (vec_x == '0) && (vec_y == '0);
    if (vec_x[VEC_W-1]) begin
      if (!vec_y[VEC_W-1]) begin
        p_x <= PW'(vec_y);
        p_y <= -PW'(vec_x);
        p_z <= RES_W'(ANG_QUARTER);
      end else begin
        p_x <= -PW'(vec_y);
        p_y <= PW'(vec_x);
        p_z <= -RES_W'(ANG_QUARTER);
      end
    end else begin
      p_x <= PW'(vec_x);
      p_y <= PW'(vec_y);
      p_z <= '0;
    end
  end

  assign abs_x = p_x[PW-1] ? PW'(-p_x) : PW'(p_x);
  assign abs_y = p_y[PW-1] ? PW'(-p_y) : PW'(p_y);

  always_ff @(posedge clk) begin
    m_x    <= p_x;
    m_y    <= p_y;
    m_z    <= p_z;
    m_zero <= p_zero;
    m_mx   <= (abs_x > abs_y) ? MXW'(abs_x) : MXW'(abs_y);
  end

  // Normalize: coarse shifts of 32, 16, 8
  always_comb begin
    c1_mx = m_mx;
    c1_x  = NW'(m_x);
    c1_y  = NW'(m_y);
    for (int k = 5; k >= 3; k--) begin
      if (c1_mx < (MXW'(1) << (NORM_BIT + 1 - (1 << k)))) begin
        c1_mx = c1_mx << (1 << k);
        c1_x  = c1_x <<< (1 << k);
        c1_y  = c1_y <<< (1 << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    n1_mx   <= c1_mx;
    n1_x    <= c1_x;
    n1_y    <= c1_y;
    n1_z    <= m_z;
    n1_zero <= m_zero;
  end

  // Normalize: fine shifts of 4, 2, 1
  always_comb begin
    c2_mx = n1_mx;
    c2_x  = n1_x;
    c2_y  = n1_y;
    for (int k = 2; k >= 0; k--) begin
      if (c2_mx < (MXW'(1) << (NORM_BIT + 1 - (1 << k)))) begin
        c2_mx = c2_mx << (1 << k);
        c2_x  = c2_x <<< (1 << k);
        c2_y  = c2_y <<< (1 << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    it_x[0]    <= c2_x;
    it_y[0]    <= c2_y;
    it_z[0]    <= n1_z;
    it_zero[0] <= n1_zero;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        it_v[i+1] <= 1'b0;
      end else begin
        it_v[i+1] <= it_v[i];
      end
    end

    always_ff @(posedge clk) begin
      it_zero[i+1] <= it_zero[i];
      if (!it_y[i][NW-1]) begin
        it_x[i+1] <= it_x[i] + (it_y[i] >>> i);
        it_y[i+1] <= it_y[i] - (it_x[i] >>> i);
        it_z[i+1] <= it_z[i] + ATAN_TAB[i];
      end else begin
        it_x[i+1] <= it_x[i] - (it_y[i] >>> i);
        it_y[i+1] <= it_y[i] + (it_x[i] >>> i);
        it_z[i+1] <= it_z[i] - ATAN_TAB[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= it_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    angle <= it_zero[CORDIC_STEPS] ? '0 : it_z[CORDIC_STEPS];
  end

endmodule

FILE: rtl/great_circle_distance_bearing_top.sv
// ----------------------------------------------------------------------------
// great_circle_distance_bearing_top: haversine distance and initial bearing
// Fixed-point pipeline: CORDIC sin/cos, Q30 products, square roots, atan2.
// ----------------------------------------------------------------------------
// Usage
//   Drive own_lat/own_lon/target_lat/target_lon (degrees * 65536) and raise
//   start. A word is taken at every rising edge where start is high and busy
//   is low. busy never rises: the pipeline takes a new word every cycle.
//   Each word gives one result word: done is high for exactly one cycle with
//   distance_km (1/16 km, saturating at 320256) and bearing_deg (degrees *
//   65536 in [0,360), 0 is north, clockwise).
//   Throughput is one word per clock. The depth is set by the 23-stage
//   sine/cosine CORDIC, the 31-stage square root and the 23-stage atan2
//   CORDIC running back to back, one iteration per stage.
//   The receiver cannot stall: results stream out in input order.
//   Synchronous reset clears every valid bit, dropping words in flight;
//   the block keeps no other state.
// ----------------------------------------------------------------------------
module great_circle_distance_bearing_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] own_lat,
  input  logic signed [24:0] own_lon,
  input  logic signed [23:0] target_lat,
  input  logic signed [24:0] target_lon,
  output logic               done,
  output logic        [18:0] distance_km,
  output logic        [24:0] bearing_deg
);
  import gcdb_pkg::*;

  localparam logic [26:0] DMUL = 27'(DIST_MUL);

  // Input stage: angles for the five sin/cos units
  logic                     a_v;
  logic signed [ANG_W-1:0]  ang_lat1, ang_lat2, ang_dlat, ang_dlon, ang_dlon2;
  logic signed [ANG_W-1:0]  dlon;

  // Sin/cos results
  logic                     sc_v;
  logic signed [TRIG_W-1:0] s1, c1, s2, c2, shl, sho, sd, cd;

  // Haversine term
  logic                     d1_v, d2_v, d3_v;
  logic signed [TRIG_W-1:0] p1, q, c1_d1, c2_d1;
  logic signed [TRIG_W-1:0] r, p1_d2, c2_d2;
  logic signed [TRIG_W-1:0] t, p1_d3;
  logic signed [TRIG_W:0]   hsum;
  logic        [SQ_W-1:0]   a_cl;

  // Square roots, lane 0 is a, lane 1 is 1 - a
  logic                     sq_v    [SQ_STEPS+1];
  logic        [SQ_W:0]     sq_op   [SQ_STEPS+1][2];
  logic        [SQ_W+3:0]   sq_rem  [SQ_STEPS+1][2];
  logic        [SQ_W-1:0]   sq_root [SQ_STEPS+1][2];

  // Bearing vector
  logic signed [TRIG_W-1:0] by, bu, bv, cd_d1, bw, by_d2, bu_d2;
  logic signed [VEC_W-1:0]  bx, by_d3;
  logic signed [VEC_W-1:0]  dly_x [BRG_DLY];
  logic signed [VEC_W-1:0]  dly_y [BRG_DLY];

  // atan2 results and output stages
  logic                     zd_v, d5_v;
  logic signed [RES_W-1:0]  zd, zb;
  logic        [RES_W-2:0]  zpos;
  logic        [51:0]       dprod, dsum;
  logic        [19:0]       dq;
  logic        [RES_W-1:0]  bpos;
  logic        [RES_W:0]    bo_sum;
  logic        [RES_W-1:0]  bo;

  assign busy = 1'b0;
  assign dlon = ANG_W'(target_lon) - ANG_W'(own_lon);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= start & ~busy;
    end
  end

  // Latitudes doubled into internal units; differences are already halves
  always_ff @(posedge clk) begin
    ang_lat1  <= ANG_W'(own_lat) <<< 1;
    ang_lat2  <= ANG_W'(target_lat) <<< 1;
    ang_dlat  <= ANG_W'(target_lat) - ANG_W'(own_lat);
    ang_dlon  <= dlon;
    ang_dlon2 <= dlon <<< 1;
  end

  gcdb_sincos u_sc_lat1 (
    .clk(clk), .rst(rst), .in_valid(a_v), .angle(ang_lat1),
    .out_valid(sc_v), .sin_val(s1), .cos_val(c1)
  );
  gcdb_sincos u_sc_lat2 (
    .clk(clk), .rst(rst), .in_valid(a_v), .angle(ang_lat2),
    .out_valid(), .sin_val(s2), .cos_val(c2)
  );
  gcdb_sincos u_sc_hlat (
    .clk(clk), .rst(rst), .in_valid(a_v), .angle(ang_dlat),
    .out_valid(), .sin_val(shl), .cos_val()
  );
  gcdb_sincos u_sc_hlon (
    .clk(clk), .rst(rst), .in_valid(a_v), .angle(ang_dlon),
    .out_valid(), .sin_val(sho), .cos_val()
  );
  gcdb_sincos u_sc_dlon (
    .clk(clk), .rst(rst), .in_valid(a_v), .angle(ang_dlon2),
    .out_valid(), .sin_val(sd), .cos_val(cd)
  );

  // Valid chain through the product stages
  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v     <= 1'b0;
      d2_v     <= 1'b0;
      d3_v     <= 1'b0;
      sq_v[0]  <= 1'b0;
    end else begin
      d1_v     <= sc_v;
      d2_v     <= d1_v;
      d3_v     <= d2_v;
      sq_v[0]  <= d3_v;
    end
  end

  // a = sin^2(dlat/2) + sin^2(dlon/2) * cos(lat1) * cos(lat2)
  always_ff @(posedge clk) begin
    p1    <= mul_q30(shl, shl);
    q     <= mul_q30(sho, sho);
    c1_d1 <= c1;
    c2_d1 <= c2;
    r     <= mul_q30(q, c1_d1);
    p1_d2 <= p1;
    c2_d2 <= c2_d1;
    t     <= mul_q30(r, c2_d2);
    p1_d3 <= p1_d2;
  end

  // Clamp a into [0,1]
  always_comb begin
    hsum = (TRIG_W+1)'(p1_d3) + (TRIG_W+1)'(t);
    priority if (hsum[TRIG_W]) begin
      a_cl = '0;
    end else if (hsum > (TRIG_W+1)'(Q30_ONE)) begin
      a_cl = SQ_W'(Q30_ONE);
    end else begin
      a_cl = SQ_W'(hsum);
    end
  end

  // Square-root argument is a << 30: load a into the top of the operand
  always_ff @(posedge clk) begin
    sq_op[0][0]   <= {1'b0, a_cl};
    sq_op[0][1]   <= {1'b0, SQ_W'(Q30_ONE) - a_cl};
    sq_rem[0][0]  <= '0;
    sq_rem[0][1]  <= '0;
    sq_root[0][0] <= '0;
    sq_root[0][1] <= '0;
  end

  // One root bit per stage: shift in two operand bits, try subtract
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else begin
        sq_v[j+1] <= sq_v[j];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [SQ_W+3:0] rem_t;
      logic [SQ_W+3:0] trial;

      assign rem_t = {sq_rem[j][l][SQ_W+1:0], sq_op[j][l][SQ_W:SQ_W-1]};
      assign trial = (SQ_W+4)'({sq_root[j][l], 2'b01});

      always_ff @(posedge clk) begin
        sq_op[j+1][l] <= sq_op[j][l] << 2;
        if (rem_t >= trial) begin
          sq_rem[j+1][l]  <= rem_t - trial;
          sq_root[j+1][l] <= {sq_root[j][l][SQ_W-2:0], 1'b1};
        end else begin
          sq_rem[j+1][l]  <= rem_t;
          sq_root[j+1][l] <= {sq_root[j][l][SQ_W-2:0], 1'b0};
        end
      end
    end
  end

  // Bearing vector: y = sin(dlon) cos(lat2),
  // x = cos(lat1) sin(lat2) - sin(lat1) cos(lat2) cos(dlon)
  always_ff @(posedge clk) begin
    by    <= mul_q30(sd, c2);
    bu    <= mul_q30(c1, s2);
    bv    <= mul_q30(s1, c2);
    cd_d1 <= cd;
    bw    <= mul_q30(bv, cd_d1);
    by_d2 <= by;
    bu_d2 <= bu;
    bx    <= VEC_W'(bu_d2) - VEC_W'(bw);
    by_d3 <= VEC_W'(by_d2);
  end

  // Hold the bearing vector until the square roots finish
  always_ff @(posedge clk) begin
    dly_x[0] <= bx;
    dly_y[0] <= by_d3;
    for (int k = 1; k < BRG_DLY; k++) begin
      dly_x[k] <= dly_x[k-1];
      dly_y[k] <= dly_y[k-1];
    end
  end

  gcdb_atan2 u_atan_dist (
    .clk(clk), .rst(rst), .in_valid(sq_v[SQ_STEPS]),
    .vec_y($signed(VEC_W'(sq_root[SQ_STEPS][0]))),
    .vec_x($signed(VEC_W'(sq_root[SQ_STEPS][1]))),
    .out_valid(zd_v), .angle(zd)
  );

  gcdb_atan2 u_atan_brg (
    .clk(clk), .rst(rst), .in_valid(sq_v[SQ_STEPS]),
    .vec_y(dly_y[BRG_DLY-1]), .vec_x(dly_x[BRG_DLY-1]),
    .out_valid(), .angle(zb)
  );

  // Distance: drop negative central angle, scale by radius, round
  assign zpos = zd[RES_W-1] ? '0 : zd[RES_W-2:0];
  assign dsum = dprod + (52'(1) << 31);
  assign dq   = dsum[51:32];

  // Bearing: wrap into one turn, halve with rounding, wrap 360 to 0
  assign bo_sum = (RES_W+1)'(bpos) + (RES_W+1)'(1);
  assign bo     = bo_sum[RES_W:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d5_v <= 1'b0;
      done <= 1'b0;
    end else begin
      d5_v <= zd_v;
      done <= d5_v;
    end
  end

  always_ff @(posedge clk) begin
    dprod <= zpos * DMUL;
    bpos  <= RES_W'(zb) + (zb[RES_W-1] ? RES_W'(ANG_TURN) : '0);
    distance_km <= (dq > 20'(DIST_MAX)) ? 19'(DIST_MAX) : dq[18:0];
    bearing_deg <= (bo >= RES_W'(OUT_BEARING_TURN)) ?
                   25'(bo - RES_W'(OUT_BEARING_TURN)) : bo[24:0];
  end

  // Every accepted word comes out as a done strobe
  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word did not produce a result");

  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without an accepted word");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (distance_km <= 19'(DIST_MAX)) && (bearing_deg < 25'(OUT_BEARING_TURN)))
    else $error("result out of range");

endmodule

FILE: sim/great_circle_distance_bearing_top_tb.sv
// ----------------------------------------------------------------------------
// great_circle_distance_bearing_top_tb: self-checking bench for the haversine
// distance and initial bearing pipeline. Each input word is predicted by a
// fixed-point model, queued, and compared in order with the done strobes.
// ----------------------------------------------------------------------------
module great_circle_distance_bearing_top_tb;
  import gcdb_pkg::*;

  typedef struct {
    logic signed [23:0] own_lat;
    logic signed [24:0] own_lon;
    logic signed [23:0] target_lat;
    logic signed [24:0] target_lon;
  } coord_word_t;

  typedef struct {
    logic [18:0] distance_km;
    logic [24:0] bearing_deg;
  } course_t;

  localparam int PIPE_DEPTH  = 92;
  localparam int CYCLE_LIMIT = 200000;

  // Arctangent table in 2^-17 degree units, one entry per CORDIC iteration.
  localparam longint ROT_TAB [23] = '{
    5898240, 3481934, 1839759, 933890, 468757, 234607, 117332, 58670,
    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [23:0] own_lat = '0;
  logic signed [24:0] own_lon = '0;
  logic signed [23:0] target_lat = '0;
  logic signed [24:0] target_lon = '0;
  logic               done;
  logic        [18:0] distance_km;
  logic        [24:0] bearing_deg;

  coord_word_t pending_words[$];
  course_t     expected_courses[$];
  bit          stim_loaded = 1'b0;
  bit          any_error = 1'b0;
  bit          calm_stretch = 1'b0;
  int          cycle_count = 0;

  great_circle_distance_bearing_top u_top (
    .clk, .rst, .start, .busy, .own_lat, .own_lon, .target_lat, .target_lon,
    .done, .distance_km, .bearing_deg
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Floor shift on a signed 64-bit value.
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Rotation CORDIC: sine and cosine in Q30 of an internal angle.
  function automatic void sine_cosine(longint ang, output longint s, output longint c);
    longint r, x, y, nx;
    bit     flip;
    r = ang % ANG_TURN;
    flip = 1'b0;
    x = CORDIC_GAIN;
    y = 0;
    if (r < 0) r += ANG_TURN;
    if (r >= ANG_HALF) r -= ANG_TURN;
    if (r > ANG_QUARTER) begin
      r = ANG_HALF - r;
      flip = 1'b1;
    end else if (r < -ANG_QUARTER) begin
      r = -ANG_HALF - r;
      flip = 1'b1;
    end
    for (int i = 0; i < 23; i++) begin
      if (r >= 0) begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        r -= ROT_TAB[i];
      end else begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        r += ROT_TAB[i];
      end
      x = nx;
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  // Vectoring CORDIC arctangent in internal angle units.
  function automatic longint arc_tangent(longint y, longint x);
    longint z, t, mx, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = ANG_QUARTER;
      end else begin
        t = x; x = -y; y = t; z = -ANG_QUARTER;
      end
    end
    mx = ((x < 0) ? -x : x) > ((y < 0) ? -y : y) ? ((x < 0) ? -x : x)
                                                 : ((y < 0) ? -y : y);
    while (mx < (64'sd1 <<< 40)) begin
      x *= 2; y *= 2; mx *= 2;
    end
    for (int i = 0; i < 23; i++) begin
      if (y >= 0) begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z += ROT_TAB[i];
      end else begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z -= ROT_TAB[i];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic course_t predict_course(coord_word_t w);
    longint lat1, lon1, lat2, lon2, dlat, dlon;
    longint s1, c1, s2, c2, shl, chl, sho, cho, sd, cd;
    longint hav, z, y, x, b;
    longint unsigned sa, sb, dist_q, bo;
    course_t res;
    lat1 = w.own_lat;
    lon1 = w.own_lon;
    lat2 = w.target_lat;
    lon2 = w.target_lon;
    dlat = lat2 - lat1;
    dlon = lon2 - lon1;
    sine_cosine(lat1 * 2, s1, c1);
    sine_cosine(lat2 * 2, s2, c2);
    sine_cosine(dlat, shl, chl);
    sine_cosine(dlon, sho, cho);
    sine_cosine(dlon * 2, sd, cd);
    hav = floor_shr(shl * shl, 30)
        + floor_shr(floor_shr(floor_shr(sho * sho, 30) * c1, 30) * c2, 30);
    if (hav < 0) hav = 0;
    if (hav > Q30_ONE) hav = Q30_ONE;
    sa = floor_root(longint'(hav) << 30);
    sb = floor_root(longint'(Q30_ONE - hav) << 30);
    z = arc_tangent(longint'(sa), longint'(sb));
    if (z < 0) z = 0;
    dist_q = (longint'(z) * DIST_MUL + (64'd1 << 31)) >> 32;
    if (dist_q > DIST_MAX) dist_q = DIST_MAX;
    y = floor_shr(sd * c2, 30);
    x = floor_shr(c1 * s2, 30) - floor_shr(floor_shr(s1 * c2, 30) * cd, 30);
    b = arc_tangent(y, x) % ANG_TURN;
    if (b < 0) b += ANG_TURN;
    bo = (longint'(b) + 1) >> 1;
    if (bo >= OUT_BEARING_TURN) bo -= OUT_BEARING_TURN;
    res.distance_km = dist_q[18:0];
    res.bearing_deg = bo[24:0];
    return res;
  endfunction

  function automatic coord_word_t make_word(int a, int b, int c, int d);
    coord_word_t w;
    w.own_lat = a;
    w.own_lon = b;
    w.target_lat = c;
    w.target_lon = d;
    return w;
  endfunction

  // Fill the stimulus queue: directed corners first, then random points.
  initial begin
    int lat, lon;
    // same point, and the origin
    pending_words.push_back(make_word(0, 0, 0, 0));
    pending_words.push_back(make_word(3276800, 1966080, 3276800, 1966080));
    // antipodes: haversine term at its top
    pending_words.push_back(make_word(0, 0, 0, 11796480));
    pending_words.push_back(make_word(5898240, 0, -5898240, 0));
    pending_words.push_back(make_word(-5898240, -11796480, 5898240, 11796480));
    // poles as start or target; zero bearing vector when both are at a pole
    pending_words.push_back(make_word(5898240, 0, 5898240, 655360));
    pending_words.push_back(make_word(-5898240, 100, 0, 0));
    pending_words.push_back(make_word(0, 0, 5898240, 0));
    // due east, west, south and north-west
    pending_words.push_back(make_word(0, 0, 0, 65536));
    pending_words.push_back(make_word(0, 0, 0, -65536));
    pending_words.push_back(make_word(0, 0, -65536, 0));
    pending_words.push_back(make_word(0, 0, 1, -1));
    // smallest steps
    pending_words.push_back(make_word(0, 0, 1, 0));
    pending_words.push_back(make_word(0, 0, 0, 1));
    // out-of-range patterns at the field extremes, and one in-range antipode
    pending_words.push_back(make_word(-8388608, -16777216, 8388607, 16777215));
    pending_words.push_back(make_word(8388607, 16777215, -8388608, -16777216));
    pending_words.push_back(make_word(-1, -1, 8388607, -16777216));
    pending_words.push_back(make_word(-8388608, 16777215, 0, 0));
    pending_words.push_back(make_word(5898240, 11796480, -5898240, -11796480));
    for (int n = 0; n < 1750; n++) begin
      case ($urandom_range(9))
        0: pending_words.push_back(make_word($urandom, $urandom, $urandom, $urandom));
        1, 2: begin
          // nearby target
          lat = $urandom_range(11796480) - 5898240;
          lon = $urandom_range(23592960) - 11796480;
          pending_words.push_back(make_word(lat, lon,
            lat + int'($urandom_range(2000)) - 1000,
            lon + int'($urandom_range(2000)) - 1000));
        end
        default:
          pending_words.push_back(make_word(
            $urandom_range(11796480) - 5898240, $urandom_range(23592960) - 11796480,
            $urandom_range(11796480) - 5898240, $urandom_range(23592960) - 11796480));
      endcase
    end
    stim_loaded = 1'b1;
  end

  // Driver: present words at the falling edge; advance on acceptance.
  always @(negedge clk) begin
    coord_word_t w;
    if (rst) begin
      start <= 1'b0;
    end else begin
      // accepted at the last rising edge: pop it and predict
      if (start && !busy) begin
        expected_courses.push_back(predict_course(pending_words.pop_front()));
      end
      calm_stretch = (cycle_count > 4000 && cycle_count < 5500);
      if (pending_words.size() > 0 && (calm_stretch || $urandom_range(99) >= 9)) begin
        w = pending_words[0];
        start      <= 1'b1;
        own_lat    <= w.own_lat;
        own_lon    <= w.own_lon;
        target_lat <= w.target_lat;
        target_lon <= w.target_lon;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each done word with the oldest expectation.
  always @(posedge clk) begin
    course_t exp_c;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (expected_courses.size() == 0) begin
        $error("unexpected result word: distance_km %0d bearing_deg %0d",
               distance_km, bearing_deg);
        any_error = 1'b1;
      end else begin
        exp_c = expected_courses.pop_front();
        if (distance_km !== exp_c.distance_km) begin
          $error("distance_km expected %0d actual %0d", exp_c.distance_km, distance_km);
          any_error = 1'b1;
        end
        if (bearing_deg !== exp_c.bearing_deg) begin
          $error("bearing_deg expected %0d actual %0d", exp_c.bearing_deg, bearing_deg);
          any_error = 1'b1;
        end
      end
    end
  end

  // Hold reset, then wait for the queues to drain and the pipe to flush.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (stim_loaded);
    while ((pending_words.size() > 0 || start || expected_courses.size() > 0)
           && cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
    end else begin
      repeat (PIPE_DEPTH + 8) @(posedge clk);
      #1;
      if (!any_error && expected_courses.size() == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end

endmodule
